@@ src/ssp_pkg.sv @@
package ssp_pkg;

	localparam int unsigned MAX_DAYS_DEFAULT = 4096;
	localparam int unsigned PRICE_W          = 32;
	localparam int unsigned SPAN_W           = 13;
	localparam int unsigned IN_TDATA_W       = 32;
	localparam int unsigned OUT_TDATA_W      = 16;

	// commands from the controller to the datapath
	typedef struct packed {
		logic take;
		logic pop;
		logic push;
		logic finish;
		logic emit;
	} ssp_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic full;
		logic top_lt;
		logic out_free;
	} ssp_sts_t;

endpackage

@@ src/ssp_ram.sv @@
module ssp_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ src/ssp_ctrl.sv @@
module ssp_ctrl import ssp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  ssp_sts_t sts,
	output ssp_cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CMP  = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.take = 1'b1;
					state_d  = sts.full ? S_DONE : S_CMP;
				end
			end
			S_CMP: begin
				if (sts.top_lt) begin
					cmd.pop = 1'b1;
				end else begin
					cmd.push   = 1'b1;
					cmd.finish = 1'b1;
					if (sts.out_free) begin
						cmd.emit = 1'b1;
						state_d  = S_IDLE;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_DONE: begin
				// finish repeats harmlessly after a push: clearing is idempotent
				if (sts.out_free) begin
					cmd.emit   = 1'b1;
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ src/ssp_dp.sv @@
module ssp_dp import ssp_pkg::*; #(
	parameter int unsigned MAX_DAYS = MAX_DAYS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [PRICE_W-1:0] price,
	input  logic               last_day,
	input  ssp_cmd_t           cmd,
	output ssp_sts_t           sts,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [SPAN_W-1:0]  out_span,
	output logic               out_ovf
);

	localparam int unsigned AW    = $clog2(MAX_DAYS);
	localparam int unsigned LW    = $clog2(MAX_DAYS + 1);
	localparam int unsigned ENT_W = PRICE_W + SPAN_W;

	logic [PRICE_W-1:0] cur_price_q;
	logic               last_q;
	logic [SPAN_W-1:0]  span_q;
	logic               ovf_q;
	logic [LW-1:0]      level_q;
	logic [LW-1:0]      days_q;
	logic [PRICE_W-1:0] top_price_q;
	logic [SPAN_W-1:0]  top_span_q;
	logic               use_ram_q;
	logic               out_valid_q;
	logic [SPAN_W-1:0]  out_span_q;
	logic               out_ovf_q;

	logic [ENT_W-1:0]   rd_data;
	logic [PRICE_W-1:0] top_price;
	logic [SPAN_W-1:0]  top_span;
	logic [LW-1:0]      rd_lvl;
	logic               full;

	// top of stack: cached after a push, fresh from memory right after a pop
	assign top_price = use_ram_q ? rd_data[ENT_W-1:SPAN_W] : top_price_q;
	assign top_span  = use_ram_q ? rd_data[SPAN_W-1:0] : top_span_q;
	assign rd_lvl    = level_q - LW'(2);
	assign full      = (days_q == LW'(MAX_DAYS));

	assign sts.full     = full;
	assign sts.top_lt   = (level_q != '0) && (top_price < cur_price_q);
	assign sts.out_free = !out_valid_q || out_ready;

	ssp_ram #(
		.WIDTH(ENT_W),
		.DEPTH(MAX_DAYS)
	) u_stack (
		.clk  (clk),
		.we   (cmd.push),
		.waddr(level_q[AW-1:0]),
		.wdata({cur_price_q, span_q}),
		.re   (cmd.pop),
		.raddr(rd_lvl[AW-1:0]),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= '0;
			days_q      <= '0;
			use_ram_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.pop) begin
				level_q   <= level_q - LW'(1);
				use_ram_q <= 1'b1;
			end else if (cmd.push) begin
				level_q   <= level_q + LW'(1);
				use_ram_q <= 1'b0;
			end
			if (cmd.push) begin
				days_q <= days_q + LW'(1);
			end
			if (cmd.finish && last_q) begin
				level_q <= '0;
				days_q  <= '0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			cur_price_q <= price;
			last_q      <= last_day;
			ovf_q       <= full;
			span_q      <= full ? '0 : SPAN_W'(1);
		end else if (cmd.pop) begin
			span_q <= span_q + top_span;
		end
		if (cmd.push) begin
			top_price_q <= cur_price_q;
			top_span_q  <= span_q;
		end
		if (cmd.emit) begin
			out_span_q <= span_q;
			out_ovf_q  <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_span  = out_span_q;
	assign out_ovf   = out_ovf_q;

endmodule

@@ src/stock_span_previous_greater_unit.sv @@
// Stock span unit: each input transaction carries one day's unsigned price on s_tdata and
// s_tlast to mark the last day of a series; each yields one result transaction with the
// span (1 plus the run of directly preceding days with strictly lower price) on m_tdata
// and an overflow flag on m_tuser. A series longer than MAX_DAYS gives span 0 with the
// overflow flag and leaves the stack untouched. Items are handled one at a time: an item
// runs the single compare/pop loop against the stack memory, popping each lower entry
// (each entry is popped at most once) and then pushing itself. The top entry is cached
// after a push and read fresh from memory after a pop. A finished result sits in the
// output register, so the next item is taken while it waits; the block only stalls if a
// second result is ready before the first is taken. The stack is one MAX_DAYS x 45-bit
// memory that needs no clearing after reset.
module stock_span_previous_greater_unit import ssp_pkg::*; #(
	parameter int unsigned MAX_DAYS = MAX_DAYS_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] price
	input  logic                   s_tlast,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [12:0] span, [15:13] zero
	output logic [0:0]             m_tuser    // [0] overflow
);

	ssp_cmd_t          cmd;
	ssp_sts_t          sts;
	logic [SPAN_W-1:0] span;
	logic              ovf;

	ssp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	ssp_dp #(
		.MAX_DAYS(MAX_DAYS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.price    (s_tdata[PRICE_W-1:0]),
		.last_day (s_tlast),
		.cmd      (cmd),
		.sts      (sts),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_span (span),
		.out_ovf  (ovf)
	);

	assign m_tdata    = {{(OUT_TDATA_W - SPAN_W){1'b0}}, span};
	assign m_tuser[0] = ovf;

endmodule

@@ src/ssp_checker.sv @@
module ssp_checker import ssp_pkg::*; #(
	parameter int unsigned MAX_DAYS = MAX_DAYS_DEFAULT
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic [0:0]             m_tuser
);

	// a result waiting for the sink stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// an overflowed day reports span zero
	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[SPAN_W-1:0] == '0)
		else $error("overflow with nonzero span");

	// a processed day has a span of at least one (not checked when MAX_DAYS >= 8192, where the span can wrap)
	a_span_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> (MAX_DAYS >= 8192) || (m_tdata[SPAN_W-1:0] != '0))
		else $error("processed day with zero span");

	// one item at a time: no new item right after one is taken
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("back to back acceptance");

endmodule

bind stock_span_previous_greater_unit ssp_checker #(
	.MAX_DAYS(MAX_DAYS)
) u_ssp_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

@@ tb/sv/testbench.sv @@
module testbench;
	import ssp_pkg::*;

	localparam int unsigned DAYS_MAX    = MAX_DAYS_DEFAULT;
	localparam int unsigned CYCLE_LIMIT = 800000;
	localparam int unsigned TAIL_CYCLES = 40;
	localparam int unsigned RANDOM_DAYS = 800;

	typedef struct packed {
		logic [SPAN_W-1:0] span;
		logic              overflow;
	} day_span_t;

	typedef enum int {
		SHAPE_RANDOM,
		SHAPE_LOW,
		SHAPE_HIGH,
		SHAPE_RISING,
		SHAPE_FALLING
	} price_shape_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;   // [31:0] price
	logic                   s_tlast = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;        // [12:0] span, [15:13] zero
	logic [0:0]             m_tuser;        // [0] overflow

	// predictor state: the monotonic stack of (price, span) for the open series
	bit [PRICE_W-1:0] stack_prices [DAYS_MAX];
	bit [SPAN_W-1:0]  stack_spans  [DAYS_MAX];
	int unsigned      stack_depth = 0;
	int unsigned      series_len  = 0;

	day_span_t   pending_spans [$];
	day_span_t   want;
	bit          steady = 1'b0;
	int unsigned errors = 0;
	int unsigned cycles = 0;
	int unsigned days_sent = 0;
	int unsigned series_sent = 0;
	int unsigned results_checked = 0;
	int unsigned overflow_seen = 0;
	int unsigned deepest_stack = 0;

	stock_span_previous_greater_unit #(
		.MAX_DAYS(DAYS_MAX)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: no progress within %0d cycles", $time, CYCLE_LIMIT);
			$display("testbench: FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= 27);
	end

	// span of one day against the stack, then the series bookkeeping
	function automatic day_span_t predict_span(bit [PRICE_W-1:0] price, bit last_day);
		day_span_t   r;
		int unsigned span_sum;
		r = '0;
		span_sum = 0;
		if (series_len >= DAYS_MAX) begin
			r.overflow = 1'b1;
		end else begin
			span_sum = 1;
			while (stack_depth > 0 && stack_prices[stack_depth-1] < price) begin
				span_sum += stack_spans[stack_depth-1];
				stack_depth--;
			end
			if (stack_depth < DAYS_MAX) begin
				stack_prices[stack_depth] = price;
				stack_spans[stack_depth]  = span_sum[SPAN_W-1:0];
				stack_depth++;
			end
			if (stack_depth > deepest_stack)
				deepest_stack = stack_depth;
			series_len++;
		end
		if (last_day) begin
			stack_depth = 0;
			series_len  = 0;
		end
		r.span = span_sum[SPAN_W-1:0];
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_spans.size() == 0) begin
				$display("%0t: result with no day pending: span %0d overflow %0b",
					$time, m_tdata[SPAN_W-1:0], m_tuser[0]);
				errors++;
			end else begin
				want = pending_spans.pop_front();
				if (m_tdata[SPAN_W-1:0] !== want.span) begin
					$display("%0t: span expected %0d actual %0d",
						$time, want.span, m_tdata[SPAN_W-1:0]);
					errors++;
				end
				if (m_tuser[0] !== want.overflow) begin
					$display("%0t: overflow expected %0b actual %0b",
						$time, want.overflow, m_tuser[0]);
					errors++;
				end
				if (want.overflow)
					overflow_seen++;
				results_checked++;
			end
		end
	end

	// one day per transaction; valid stays high on return so back-to-back days need no gap
	task automatic send_day(input bit [PRICE_W-1:0] price, input bit last_day);
		int unsigned gap;
		gap = 0;
		while (!steady && $urandom_range(99) < 27)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= price;
		s_tlast  <= last_day;
		do @(posedge clk); while (!s_tready);
		pending_spans.push_back(predict_span(price, last_day));
		days_sent++;
		if (last_day)
			series_sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_spans.size() != 0);
	endtask

	task automatic test_directed_spans();
		send_day(32'h0000_0000, 1'b1);
		// textbook series: 1 1 1 2 1 4 6
		send_day(32'd100, 1'b0);
		send_day(32'd80, 1'b0);
		send_day(32'd60, 1'b0);
		send_day(32'd70, 1'b0);
		send_day(32'd60, 1'b0);
		send_day(32'd75, 1'b0);
		send_day(32'd85, 1'b1);
		// equal prices stop the scan
		send_day(32'd7, 1'b0);
		send_day(32'd7, 1'b0);
		send_day(32'd7, 1'b1);
		send_day(32'h0000_0000, 1'b0);
		send_day(32'hFFFF_FFFF, 1'b0);
		send_day(32'hFFFF_FFFF, 1'b0);
		send_day(32'h0000_0000, 1'b0);
		send_day(32'hFFFF_FFFF, 1'b1);
		// unsigned compare across the top bit
		send_day(32'h8000_0000, 1'b0);
		send_day(32'h7FFF_FFFF, 1'b0);
		send_day(32'h8000_0000, 1'b1);
		wait_drained();
	endtask

	task automatic test_random_series();
		int unsigned  sent;
		int unsigned  len;
		bit [31:0]    price;
		bit [31:0]    base;
		price_shape_t shape;
		sent = 0;
		while (sent < RANDOM_DAYS) begin
			steady = (sent >= 300 && sent < 430);
			if (sent >= 500 && sent < 520)
				wait_drained();
			len   = ($urandom_range(9) == 0) ? $urandom_range(60, 300) : $urandom_range(1, 24);
			shape = price_shape_t'($urandom_range(4));
			base  = $urandom;
			for (int unsigned i = 0; i < len; i++) begin
				case (shape)
					SHAPE_RANDOM:  price = $urandom;
					SHAPE_LOW:     price = $urandom_range(7);
					SHAPE_HIGH:    price = 32'hFFFF_FFF8 | $urandom_range(7);
					SHAPE_RISING:  price = base + $urandom_range(3);
					SHAPE_FALLING: price = base - $urandom_range(3);
					default:       price = $urandom;
				endcase
				// an occasional outlier breaks up the monotonic runs
				if ($urandom_range(15) == 0)
					price = $urandom;
				base = price;
				send_day(price, i == len - 1);
			end
			sent += len;
		end
		steady = 1'b0;
		wait_drained();
	endtask

	// deep stack, one big pop, span up to the series limit, then overflow days
	task automatic test_series_overflow();
		for (int unsigned i = 0; i < DAYS_MAX / 2; i++)
			send_day(32'h1000_0000 - i, 1'b0);
		for (int unsigned i = DAYS_MAX / 2; i < DAYS_MAX; i++)
			send_day(32'h1000_0000 + i, 1'b0);
		send_day($urandom, 1'b0);
		send_day(32'hFFFF_FFFF, 1'b0);
		send_day($urandom, 1'b1);
		send_day(32'h0000_0000, 1'b1);
		wait_drained();
	endtask

	// every day is kept on the stack until it holds the whole series
	task automatic test_full_stack_overflow();
		for (int unsigned i = 0; i < DAYS_MAX; i++)
			send_day(32'hFFFF_FFFF - i, 1'b0);
		send_day(32'hFFFF_FFFF, 1'b0);
		send_day(32'h0000_0000, 1'b1);
		send_day(32'd5, 1'b0);
		send_day(32'd9, 1'b1);
		wait_drained();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_spans();
		test_random_series();
		test_series_overflow();
		test_full_stack_overflow();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d days in %0d series, stack depth up to %0d",
			days_sent, series_sent, deepest_stack);
		$display("checked %0d spans, %0d of them overflow days, %0d mismatches",
			results_checked, overflow_seen, errors);
		if (errors == 0 && pending_spans.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
src/ssp_pkg.sv
src/ssp_ram.sv
src/ssp_ctrl.sv
src/ssp_dp.sv
src/stock_span_previous_greater_unit.sv
src/ssp_checker.sv
tb/sv/testbench.sv
